// File: rtl/koct_pkg.sv
// Shared types and codes for the keyed occurrence count table.
// No dependencies; imported by the interfaces, the cell and the core.
`default_nettype none

package koct_pkg;

    typedef enum logic [1:0] {
        MODE_ADD   = 2'd0,
        MODE_QUERY = 2'd1,
        MODE_CLEAR = 2'd2,
        MODE_RSVD  = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        ST_HIT      = 3'd0,
        ST_INSERTED = 3'd1,
        ST_FULL     = 3'd2,
        ST_KIND0    = 3'd3,
        ST_QUERY    = 3'd4,
        ST_CLEARED  = 3'd5
    } t_status;

    localparam int unsigned KIND_W   = 3;
    localparam int unsigned OFFS_W   = 16;
    localparam int unsigned COUNT_W  = 16;
    localparam int unsigned SLOT_W   = 5;
    localparam int unsigned TOTAL_W  = 6;
    // Wide enough for the largest supported table (256 entries).
    localparam int unsigned SLOTX_W  = 8;
    localparam int unsigned TOTALX_W = 9;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
    localparam logic [KIND_W-1:0]  KIND_EMPTY = '0;

    // Transaction as it travels down the chain of cells.
    typedef struct packed {
        logic                       valid;
        t_mode                      mode;
        logic [KIND_W-1:0]          kind;
        logic signed [OFFS_W-1:0]   offset;
        logic                       done;
        t_status                    status;
        logic [SLOTX_W-1:0]         slot;
        logic [COUNT_W-1:0]         count;
        logic [TOTALX_W-1:0]        total;
    } t_tok;

endpackage

`default_nettype wire

// File: rtl/koct_if.sv
// Valid/ready channel interfaces for the occurrence count table.
// Depends on koct_pkg for field widths.
`default_nettype none

interface koct_in_if
    import koct_pkg::*;
;
    logic                     valid;
    logic                     ready;
    logic [1:0]               mode;
    logic [KIND_W-1:0]        var_kind;
    logic signed [OFFS_W-1:0] stack_offset;

    modport source (output valid, output mode, output var_kind, output stack_offset,
                    input ready);
    modport sink   (input valid, input mode, input var_kind, input stack_offset,
                    output ready);
endinterface

interface koct_out_if
    import koct_pkg::*;
;
    logic                  valid;
    logic                  ready;
    logic [2:0]            status;
    logic [SLOT_W-1:0]     slot;
    logic [COUNT_W-1:0]    repeat_count;
    logic [TOTAL_W-1:0]    kind_total;

    modport source (output valid, output status, output slot, output repeat_count,
                    output kind_total, input ready);
    modport sink   (input valid, input status, input slot, input repeat_count,
                    input kind_total, output ready);
endinterface

`default_nettype wire

// File: rtl/koct_cell.sv
// One table entry plus the pipeline register that hands a transaction on.
// Depends on koct_pkg.
`default_nettype none

module koct_cell
    import koct_pkg::*;
#(
    parameter int unsigned CELL_IDX = 0
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_adv,
    input  wire t_tok i_tok,
    output t_tok      o_tok
);

    logic [KIND_W-1:0]        r_kind;
    logic [KIND_W-1:0]        n_kind;
    logic signed [OFFS_W-1:0] r_offset;
    logic signed [OFFS_W-1:0] n_offset;
    logic [COUNT_W-1:0]       r_rep;
    logic [COUNT_W-1:0]       n_rep;
    t_tok                     r_tok;
    t_tok                     n_tok;

    logic w_kind_eq;
    logic w_hit;

    assign w_kind_eq = (r_kind == i_tok.kind);
    assign w_hit     = w_kind_eq && (r_offset == i_tok.offset);

    always_comb begin
        n_tok    = i_tok;
        n_kind   = r_kind;
        n_offset = r_offset;
        n_rep    = r_rep;
        if (i_tok.valid) begin
            case (i_tok.mode)
                MODE_ADD: begin
                    // Occupied entries form a prefix, so the first empty
                    // cell means no match lies further down.
                    if (!i_tok.done) begin
                        if (w_hit) begin
                            n_rep        = (r_rep == COUNT_MAX) ? r_rep : r_rep + 1'b1;
                            n_tok.done   = 1'b1;
                            n_tok.status = ST_HIT;
                            n_tok.slot   = SLOTX_W'(CELL_IDX);
                            n_tok.count  = n_rep;
                        end else if (r_kind == KIND_EMPTY) begin
                            n_kind       = i_tok.kind;
                            n_offset     = i_tok.offset;
                            n_rep        = '0;
                            n_tok.done   = 1'b1;
                            n_tok.status = ST_INSERTED;
                            n_tok.slot   = SLOTX_W'(CELL_IDX);
                            n_tok.count  = '0;
                        end
                    end
                end
                MODE_QUERY: begin
                    if (w_kind_eq) begin
                        n_tok.total = i_tok.total + 1'b1;
                    end
                end
                MODE_CLEAR: begin
                    n_kind = KIND_EMPTY;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind   <= KIND_EMPTY;
            r_offset <= '0;
            r_rep    <= '0;
            r_tok    <= '0;
        end else if (i_adv) begin
            r_kind   <= n_kind;
            r_offset <= n_offset;
            r_rep    <= n_rep;
            r_tok    <= n_tok;
        end
    end

    assign o_tok = r_tok;

    a_done_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_adv && i_tok.valid && i_tok.done |=> r_tok.done)
        else $error("resolved transaction lost its done flag");

    a_hit_ins_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tok.valid && (r_tok.status == ST_HIT || r_tok.status == ST_INSERTED)
        |-> r_tok.done)
        else $error("hit or insert status without done");

    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_adv && i_tok.valid && i_tok.mode == MODE_CLEAR |=> r_kind == KIND_EMPTY)
        else $error("clear left entry occupied");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_adv |=> $stable(r_tok.valid) && $stable(r_kind))
        else $error("cell changed while stalled");

endmodule

`default_nettype wire

// File: rtl/keyed_occurrence_count_table_core.sv
// Keyed occurrence count table: a systolic chain of TABLE_DEPTH entry cells.
// Depends on koct_pkg, koct_if and koct_cell.
//
// Usage:
//   i_in carries one transaction per item (mode, var_kind, stack_offset);
//   o_out returns exactly one result (status, slot, repeat_count,
//   kind_total) per add, query or clear. Mode 3 is accepted and dropped.
//   Each transaction walks one cell per clock when not stalled, cell 0
//   first; every cell holds one table entry and updates it as the
//   transaction passes, so later transactions always see the effect
//   of earlier ones. Each result is registered in the last cell.
//   Throughput: one transaction per cycle when not stalled; the whole chain shifts
//   together, so the rate is set by the single global advance enable.
//   Stall: while o_out.valid is high and o_out.ready low the chain
//   freezes and i_in.ready drops; the result register at the end of the
//   chain holds its transaction until taken.
//   Reset (synchronous, i_rst_n low): all entries empty, chain empty,
//   no result pending. Usable as soon as reset is released.
`default_nettype none

module keyed_occurrence_count_table_core
    import koct_pkg::*;
#(
    parameter int unsigned TABLE_DEPTH = 32
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    koct_in_if.sink    i_in,
    koct_out_if.source o_out
);

    t_tok w_tok [TABLE_DEPTH+1];
    logic w_adv;
    t_tok w_last;

    assign w_last = w_tok[TABLE_DEPTH];
    assign w_adv  = !w_last.valid || o_out.ready;
    assign i_in.ready = w_adv;

    // Entry token: kind 0 adds, queries and clears need no search.
    always_comb begin
        w_tok[0]        = '0;
        w_tok[0].valid  = i_in.valid && (t_mode'(i_in.mode) != MODE_RSVD);
        w_tok[0].mode   = t_mode'(i_in.mode);
        w_tok[0].kind   = i_in.var_kind;
        w_tok[0].offset = i_in.stack_offset;
        case (t_mode'(i_in.mode))
            MODE_ADD: begin
                if (i_in.var_kind == KIND_EMPTY) begin
                    w_tok[0].done   = 1'b1;
                    w_tok[0].status = ST_KIND0;
                end else begin
                    w_tok[0].done   = 1'b0;
                    w_tok[0].status = ST_FULL;
                end
            end
            MODE_QUERY: begin
                w_tok[0].done   = 1'b1;
                w_tok[0].status = ST_QUERY;
            end
            MODE_CLEAR: begin
                w_tok[0].done   = 1'b1;
                w_tok[0].status = ST_CLEARED;
            end
            default: begin
                w_tok[0].done   = 1'b1;
                w_tok[0].status = ST_CLEARED;
            end
        endcase
    end

    for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
        koct_cell #(
            .CELL_IDX (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (w_adv),
            .i_tok   (w_tok[g]),
            .o_tok   (w_tok[g+1])
        );
    end

    assign o_out.valid        = w_last.valid;
    assign o_out.status       = w_last.status;
    assign o_out.slot         = w_last.slot[SLOT_W-1:0];
    assign o_out.repeat_count = w_last.count;
    assign o_out.kind_total   = w_last.total[TOTAL_W-1:0];

    a_query_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.status == ST_QUERY |-> o_out.slot == '0 && o_out.repeat_count == '0)
        else $error("query result carries slot or count");

    a_nonquery_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.status != ST_QUERY |-> o_out.kind_total == '0)
        else $error("non-query result carries a total");

    a_ready_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && !o_out.ready |-> !i_in.ready)
        else $error("input taken while result stalled");

endmodule

`default_nettype wire

// File: sim/koct_table_checker.sv
// Checker for the keyed occurrence count table: watches both channels,
// keeps its own copy of the table and compares every result in order.
// Depends on koct_pkg and the koct_in_if / koct_out_if interfaces.
`timescale 1ns / 1ps

module koct_table_checker
    import koct_pkg::*;
#(
    parameter int unsigned TABLE_DEPTH = 32
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    koct_in_if          i_in_mon,
    koct_out_if         i_out_mon,
    output logic [31:0] o_fail_count,
    output logic [31:0] o_pending
);

    typedef struct packed {
        t_status              status;
        logic [SLOT_W-1:0]    slot;
        logic [COUNT_W-1:0]   count;
        logic [TOTAL_W-1:0]   total;
    } t_outcome;

    logic [KIND_W-1:0]  ent_kind  [TABLE_DEPTH];
    logic [OFFS_W-1:0]  ent_offs  [TABLE_DEPTH];
    logic [COUNT_W-1:0] ent_count [TABLE_DEPTH];

    t_outcome    awaited_q[$];
    int unsigned fail_total = 0;
    int unsigned outstanding = 0;

    assign o_fail_count = fail_total;
    assign o_pending    = outstanding;

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        $display("[%0t] MISMATCH %s: got %0d, expected %0d", $time, what, got, want);
        fail_total++;
    endtask

    function automatic void wipe_table();
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            ent_kind[i]  = KIND_EMPTY;
            ent_offs[i]  = '0;
            ent_count[i] = '0;
        end
    endfunction

    // Applies one transaction to the shadow table; returns 0 when no result is due.
    function automatic bit table_update(input t_mode m, input logic [KIND_W-1:0] k,
                                        input logic [OFFS_W-1:0] o, output t_outcome r);
        int          hole;
        int unsigned total;
        hole  = -1;
        total = 0;
        r     = '0;
        case (m)
            MODE_ADD: begin
                if (k == KIND_EMPTY) begin
                    r.status = ST_KIND0;
                    return 1'b1;
                end
                for (int i = 0; i < TABLE_DEPTH; i++) begin
                    if (ent_kind[i] == k && ent_offs[i] == o) begin
                        if (ent_count[i] != COUNT_MAX)
                            ent_count[i] = ent_count[i] + 1'b1;
                        r.status = ST_HIT;
                        r.slot   = SLOT_W'(i);
                        r.count  = ent_count[i];
                        return 1'b1;
                    end
                    if (ent_kind[i] == KIND_EMPTY && hole < 0)
                        hole = i;
                end
                if (hole < 0) begin
                    r.status = ST_FULL;
                    return 1'b1;
                end
                ent_kind[hole]  = k;
                ent_offs[hole]  = o;
                ent_count[hole] = '0;
                r.status = ST_INSERTED;
                r.slot   = SLOT_W'(hole);
                return 1'b1;
            end
            MODE_QUERY: begin
                for (int i = 0; i < TABLE_DEPTH; i++) begin
                    if (ent_kind[i] == k)
                        total++;
                end
                r.status = ST_QUERY;
                r.total  = TOTAL_W'(total);
                return 1'b1;
            end
            MODE_CLEAR: begin
                wipe_table();
                r.status = ST_CLEARED;
                return 1'b1;
            end
            default: return 1'b0;
        endcase
    endfunction

    always @(posedge i_clk) begin
        t_outcome want;
        t_outcome seen;
        if (!i_rst_n) begin
            wipe_table();
            awaited_q.delete();
        end else begin
            // results leave only after their transaction has passed every cell register, so pop first
            if (i_out_mon.valid && i_out_mon.ready) begin
                seen.status = t_status'(i_out_mon.status);
                seen.slot   = i_out_mon.slot;
                seen.count  = i_out_mon.repeat_count;
                seen.total  = i_out_mon.kind_total;
                if (awaited_q.size() == 0) begin
                    report_mismatch("result with nothing outstanding, status",
                                    seen.status, 0);
                end else begin
                    want = awaited_q.pop_front();
                    if (seen.status !== want.status)
                        report_mismatch("status", seen.status, want.status);
                    if (seen.slot !== want.slot)
                        report_mismatch("slot", seen.slot, want.slot);
                    if (seen.count !== want.count)
                        report_mismatch("repeat_count", seen.count, want.count);
                    if (seen.total !== want.total)
                        report_mismatch("kind_total", seen.total, want.total);
                end
            end
            if (i_in_mon.valid && i_in_mon.ready) begin
                if (table_update(t_mode'(i_in_mon.mode), i_in_mon.var_kind,
                                 i_in_mon.stack_offset, want))
                    awaited_q.push_back(want);
            end
        end
        outstanding = awaited_q.size();
    end

endmodule

// File: sim/keyed_occurrence_count_table_core_tb.sv
// Top of the occurrence count table testbench: clock, reset, stimulus,
// receiver back-pressure and the verdict. Depends on koct_pkg, koct_if,
// koct_table_checker and keyed_occurrence_count_table_core.
`timescale 1ns / 1ps

module keyed_occurrence_count_table_core_tb;
    import koct_pkg::*;

    localparam int unsigned TABLE_DEPTH  = 32;
    localparam int unsigned CYCLE_LIMIT  = 1_000_000;
    localparam int unsigned RANDOM_ITEMS = 840;
    localparam int unsigned POOL_MAX     = 48;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    koct_in_if  in_ch();
    koct_out_if out_ch();

    logic [31:0] fail_count;
    logic [31:0] pending;

    bit          tx_quiet = 1'b0;
    bit          rx_quiet = 1'b0;
    int unsigned cycle_cnt = 0;

    int unsigned       random_done;
    int unsigned       pool_n;
    int unsigned       burst_len;
    int unsigned       roll;
    logic [KIND_W-1:0] pool_kind [POOL_MAX];
    logic [OFFS_W-1:0] pool_offs [POOL_MAX];

    keyed_occurrence_count_table_core #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    koct_table_checker #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_mon     (in_ch),
        .i_out_mon    (out_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("keyed_occurrence_count_table_core verification failed");
            $finish;
        end
    end

    // mostly short gaps, now and then a long one
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 75)
            return $urandom_range(1, 3);
        else if (r < 95)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [OFFS_W-1:0] rand_offset();
        case ($urandom_range(0, 11))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return '0;
            3: return '1;
            default: return OFFS_W'($urandom_range(0, 65535));
        endcase
    endfunction

    // receiver stalls
    initial begin
        int unsigned rx_hold;
        rx_hold = 0;
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (rx_hold != 0) begin
                out_ch.ready = 1'b0;
                rx_hold--;
            end else begin
                out_ch.ready = 1'b1;
                if (!rx_quiet && $urandom_range(0, 5) == 0)
                    rx_hold = pick_gap();
            end
        end
    end

    // Entered and left at a falling edge; valid stays high for back-to-back items.
    task automatic put_item(input t_mode m, input logic [KIND_W-1:0] k,
                            input logic [OFFS_W-1:0] o);
        int unsigned gap;
        if (!tx_quiet && $urandom_range(0, 3) == 0) begin
            gap = pick_gap();
            in_ch.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_ch.valid        = 1'b1;
        in_ch.mode         = m;
        in_ch.var_kind     = k;
        in_ch.stack_offset = o;
        do @(posedge i_clk); while (!in_ch.ready);
        @(negedge i_clk);
    endtask

    task automatic drain();
        in_ch.valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    initial begin
        in_ch.valid        = 1'b0;
        in_ch.mode         = MODE_ADD;
        in_ch.var_kind     = '0;
        in_ch.stack_offset = '0;
        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: extremes, every mode, rejection, query of empties
        put_item(MODE_QUERY, 3'd0, 16'h0000);
        put_item(MODE_ADD,   3'd0, 16'h1234);
        put_item(MODE_ADD,   3'd7, 16'h8000);
        put_item(MODE_ADD,   3'd7, 16'h8000);
        put_item(MODE_ADD,   3'd7, 16'h7FFF);
        put_item(MODE_ADD,   3'd1, 16'h7FFF);
        put_item(MODE_ADD,   3'd1, 16'h0000);
        put_item(MODE_ADD,   3'd1, 16'hFFFF);
        put_item(MODE_RSVD,  3'd1, 16'h0000);
        put_item(MODE_ADD,   3'd1, 16'h0000);
        put_item(MODE_QUERY, 3'd7, 16'h0000);
        put_item(MODE_QUERY, 3'd1, 16'hFFFF);
        put_item(MODE_QUERY, 3'd0, 16'h8000);
        put_item(MODE_QUERY, 3'd5, 16'h7FFF);
        put_item(MODE_ADD,   3'd0, 16'hFFFF);
        put_item(MODE_CLEAR, 3'd7, 16'hFFFF);
        put_item(MODE_QUERY, 3'd7, 16'h0000);
        drain();

        // fill every slot, then overflow, hit while full, clear a full table
        for (int i = 0; i < TABLE_DEPTH; i++)
            put_item(MODE_ADD, (i == 0) ? 3'd4 : KIND_W'($urandom_range(1, 7)),
                     OFFS_W'(i * 97 + 3));
        put_item(MODE_ADD,   3'd2, 16'hABCD);
        put_item(MODE_ADD,   3'd4, 16'd3);
        put_item(MODE_ADD,   3'd0, 16'd3);
        put_item(MODE_QUERY, 3'd0, 16'h0000);
        put_item(MODE_RSVD,  3'd6, 16'hABCD);
        put_item(MODE_CLEAR, 3'd0, 16'h0000);
        drain();

        // random bursts over small key pools; some pools overflow the table
        random_done = 0;
        while (random_done < RANDOM_ITEMS) begin
            pool_n = ($urandom_range(0, 3) == 0) ? $urandom_range(33, POOL_MAX)
                                                 : $urandom_range(2, 24);
            for (int i = 0; i < pool_n; i++) begin
                pool_kind[i] = KIND_W'($urandom_range(1, 7));
                pool_offs[i] = rand_offset();
            end
            tx_quiet = ($urandom_range(0, 3) == 0);
            rx_quiet = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 1) == 0) begin
                put_item(MODE_CLEAR, KIND_W'($urandom_range(0, 7)), rand_offset());
                random_done++;
            end
            burst_len = $urandom_range(30, 120);
            for (int n = 0; n < burst_len; n++) begin
                roll = $urandom_range(0, 99);
                if (roll < 70) begin
                    roll = $urandom_range(0, pool_n - 1);
                    put_item(MODE_ADD, pool_kind[roll], pool_offs[roll]);
                end else if (roll < 80) begin
                    put_item(MODE_QUERY, KIND_W'($urandom_range(0, 7)), rand_offset());
                end else if (roll < 85) begin
                    put_item(MODE_ADD, 3'd0, rand_offset());
                end else if (roll < 88) begin
                    put_item(MODE_CLEAR, KIND_W'($urandom_range(0, 7)), rand_offset());
                end else if (roll < 91) begin
                    put_item(MODE_RSVD, KIND_W'($urandom_range(0, 7)), rand_offset());
                    random_done--;
                end else begin
                    put_item(MODE_ADD, KIND_W'($urandom_range(1, 7)), rand_offset());
                end
                random_done++;
            end
            // now and then, hold off the sender until the table has answered everything
            if ($urandom_range(0, 2) == 0)
                drain();
        end

        drain();
        repeat (TABLE_DEPTH + 16) @(negedge i_clk);
        if (fail_count == 0)
            $display("keyed_occurrence_count_table_core verification clean");
        else
            $display("keyed_occurrence_count_table_core verification failed");
        $finish;
    end

endmodule
